// ===== sv/clif_pkg.sv =====
`default_nettype none

package clif_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_COPY,
      ST_DONE
   } clif_state_type;

   localparam logic [1:0] KIND_TEXT = 2'd0;
   localparam logic [1:0] KIND_POP  = 2'd1;
   localparam logic [1:0] KIND_ARG  = 2'd2;

   localparam logic [2:0] ACT_QUEUE  = 3'd0;
   localparam logic [2:0] ACT_DELETE = 3'd1;
   localparam logic [2:0] ACT_PRINT  = 3'd2;
   localparam logic [2:0] ACT_ESTOP  = 3'd3;
   localparam logic [2:0] ACT_REPORT = 3'd4;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_NO_ROOM  = 2'd1;
   localparam logic [1:0] ERR_TOO_LONG = 2'd2;

   localparam logic [1:0] CSR_WEB_DECODE = 2'd0;
   localparam logic [1:0] CSR_SPACE_MAX  = 2'd1;
   localparam logic [1:0] CSR_SPACE_MIN  = 2'd2;

   typedef struct packed {
      logic       finish;
      logic       too_long;
      logic [2:0] act;
   } clif_line_evt_type;

   typedef struct packed {
      logic       push;
      logic [7:0] data;
      logic       pop;
   } clif_ring_ctl_type;

endpackage

`default_nettype wire

// ===== sv/command_line_intake_fifo.sv =====
// Command line intake with a byte ring FIFO.
// The req channel carries one item per handshake: req_tuser is the kind (text byte, pop,
// or line store read), req_tlast marks the end of a string, and req_tdata holds the text
// byte and the line store index. The rsp channel returns exactly one item per request;
// rsp_tlast is set when that item finished a line.
// An item passes through an execute state and a result state, with a copy state between
// them for a queued line, before rsp_tvalid rises; a new request is taken only once the
// block is back in idle. A line that is queued is copied byte by byte from the line store
// into the FIFO memory, followed by a terminating zero, through the one memory write port
// of the FIFO.
// The csr port writes a register at every edge where csr_we is high outside reset; it is
// to be used only while the block is idle, which the block itself does not enforce.
// Synchronous reset empties the FIFO, clears the line, the escape decoder and the report
// counter, and restores the register defaults.
// When the receiver stalls, the finished item waits in the output register; one further
// request is still accepted and its item is held inside until the output register frees.
`default_nettype none

module command_line_intake_fifo import clif_pkg::*; #(
   parameter int FIFO_DEPTH = 512,
   parameter int LINE_LEN   = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // [7:0] text_byte, [14:8] arg_index, [15] zero
   input  wire logic [15:0] req_tdata,
   input  wire logic        req_tlast,
   // [1:0] kind
   input  wire logic [1:0]  req_tuser,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] out_byte, [8] fifo_was_empty, [11:9] action, [13:12] error_code,
   // [20:14] line_length, [29:21] reported_space, [45:30] report_count, [47:46] zero
   output      logic [47:0] rsp_tdata,
   output      logic        rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [8:0]  csr_wdata
);

   localparam int LW = $clog2(LINE_LEN);
   localparam int FW = $clog2(FIFO_DEPTH);
   localparam int AW = ((LW > 7) ? LW : 7) + 1;
   localparam int NW = ((LW > FW) ? LW : FW) + 1;
   localparam int CW = (FW > 9) ? FW : 9;

   clif_state_type    state_ff, state_in;
   logic              accept;

   logic [1:0]        kind_ff, kind_in;
   logic [7:0]        byte_ff, byte_in;
   logic              eos_ff, eos_in;
   logic              idx_ok_ff, idx_ok_in;
   logic [AW-1:0]     idx_ext;

   logic              web_ff;
   logic [8:0]        space_max_ff;
   logic [8:0]        space_min_ff;
   logic [15:0]       report_ctr_ff, report_ctr_in;

   logic [7:0]        res_byte_ff, res_byte_in;
   logic              res_empty_ff, res_empty_in;
   logic              res_done_ff, res_done_in;
   logic [2:0]        res_act_ff, res_act_in;
   logic [1:0]        res_err_ff, res_err_in;
   logic [LW-1:0]     res_len_ff, res_len_in;
   logic [LW-1:0]     cpy_idx_ff, cpy_idx_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [47:0]       rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              line_start;
   logic [LW-1:0]     line_rd_addr;
   logic [7:0]        line_rd_data;
   clif_line_evt_type line_evt;
   logic [LW-1:0]     line_len;

   clif_ring_ctl_type ring_ctl;
   logic [7:0]        ring_rd_data;
   logic              ring_empty;
   logic [FW-1:0]     ring_free;

   logic [CW-1:0]     free_ext;
   logic [CW-1:0]     reported;

   clif_line #(
      .LINE_LEN(LINE_LEN)
   ) u_line (
      .clock   (clock),
      .reset   (reset),
      .start   (line_start),
      .char_in (byte_ff),
      .eos     (eos_ff),
      .web_on  (web_ff),
      .rd_addr (line_rd_addr),
      .rd_data (line_rd_data),
      .evt     (line_evt),
      .len_out (line_len)
   );

   clif_ring #(
      .FIFO_DEPTH(FIFO_DEPTH)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ring_ctl),
      .rd_data (ring_rd_data),
      .empty   (ring_empty),
      .free    (ring_free)
   );

   assign req_tready = state_ff == ST_IDLE;
   assign accept     = req_tvalid && req_tready;
   assign idx_ext    = AW'(req_tdata[14:8]);
   assign line_start = (state_ff == ST_EXEC) && (kind_ff == KIND_TEXT);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      free_ext = CW'(ring_free);
      if (free_ext > CW'(space_max_ff)) begin
         reported = CW'(space_max_ff);
      end else if (free_ext < CW'(space_min_ff)) begin
         reported = '0;
      end else begin
         reported = free_ext;
      end
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      byte_in       = byte_ff;
      eos_in        = eos_ff;
      idx_ok_in     = idx_ok_ff;
      report_ctr_in = report_ctr_ff;
      res_byte_in   = res_byte_ff;
      res_empty_in  = res_empty_ff;
      res_done_in   = res_done_ff;
      res_act_in    = res_act_ff;
      res_err_in    = res_err_ff;
      res_len_in    = res_len_ff;
      cpy_idx_in    = cpy_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      ring_ctl      = '0;
      line_rd_addr  = idx_ext[LW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in   = req_tuser;
               byte_in   = req_tdata[7:0];
               eos_in    = req_tlast;
               idx_ok_in = idx_ext < AW'(LINE_LEN);
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            line_rd_addr = '0;
            res_byte_in  = '0;
            res_empty_in = 1'b0;
            res_done_in  = 1'b0;
            res_act_in   = ACT_QUEUE;
            res_err_in   = ERR_NONE;
            res_len_in   = '0;
            cpy_idx_in   = '0;
            state_in     = ST_DONE;
            case (kind_ff)
               KIND_TEXT: begin
                  if (line_evt.too_long) begin
                     res_err_in = ERR_TOO_LONG;
                  end
                  if (line_evt.finish) begin
                     res_done_in = 1'b1;
                     res_act_in  = line_evt.act;
                     res_len_in  = line_len;
                     if (line_evt.act == ACT_REPORT) begin
                        report_ctr_in = report_ctr_ff + 1'b1;
                     end
                     if (line_evt.act == ACT_QUEUE) begin
                        if (NW'(line_len) + 1'b1 > NW'(ring_free)) begin
                           res_err_in = ERR_NO_ROOM;
                        end else begin
                           state_in = ST_COPY;
                        end
                     end
                  end
               end
               KIND_POP: begin
                  if (ring_empty) begin
                     res_empty_in = 1'b1;
                  end else begin
                     res_byte_in  = ring_rd_data;
                     ring_ctl.pop = 1'b1;
                  end
               end
               KIND_ARG: begin
                  res_byte_in = idx_ok_ff ? line_rd_data : 8'h00;
               end
               default: begin
               end
            endcase
         end
         ST_COPY: begin
            line_rd_addr  = cpy_idx_ff + 1'b1;
            ring_ctl.push = 1'b1;
            ring_ctl.data = (cpy_idx_ff == res_len_ff) ? 8'h00 : line_rd_data;
            cpy_idx_in    = cpy_idx_ff + 1'b1;
            if (cpy_idx_ff == res_len_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = res_done_ff;
               rsp_data_in  = {2'b00, report_ctr_ff, reported[8:0], 7'(res_len_ff),
                               res_err_ff, res_act_ff, res_empty_ff, res_byte_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         report_ctr_ff <= '0;
         web_ff        <= 1'b1;
         space_max_ff  <= 9'd511;
         space_min_ff  <= 9'd0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         report_ctr_ff <= report_ctr_in;
         if (csr_we) begin
            case (csr_index)
               CSR_WEB_DECODE: web_ff       <= csr_wdata[0];
               CSR_SPACE_MAX:  space_max_ff <= csr_wdata;
               CSR_SPACE_MIN:  space_min_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      byte_ff      <= byte_in;
      eos_ff       <= eos_in;
      idx_ok_ff    <= idx_ok_in;
      res_byte_ff  <= res_byte_in;
      res_empty_ff <= res_empty_in;
      res_done_ff  <= res_done_in;
      res_act_ff   <= res_act_in;
      res_err_ff   <= res_err_in;
      res_len_ff   <= res_len_in;
      cpy_idx_ff   <= cpy_idx_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

`default_nettype wire

// ===== sv/clif_line.sv =====
`default_nettype none

module clif_line import clif_pkg::*; #(
   parameter int LINE_LEN = 128
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [7:0]                  char_in,
   input  wire logic                        eos,
   input  wire logic                        web_on,
   input  wire logic [$clog2(LINE_LEN)-1:0] rd_addr,
   output      logic [7:0]                  rd_data,
   output      clif_line_evt_type           evt,
   output      logic [$clog2(LINE_LEN)-1:0] len_out
);

   localparam int LW = $clog2(LINE_LEN);

   localparam logic [1:0] PH_NONE = 2'd0;
   localparam logic [1:0] PH_HIGH = 2'd1;
   localparam logic [1:0] PH_LOW  = 2'd2;

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_NL      = 8'h0A;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UP_A    = 8'h41;
   localparam logic [7:0] CH_UP_Z    = 8'h5A;
   localparam logic [7:0] CH_LO_A    = 8'h61;
   localparam logic [7:0] CH_LO_Z    = 8'h7A;
   localparam logic [7:0] LETTER_OFS = 8'h37;

   localparam logic [31:0] PFX_DELETE = "M30 ";
   localparam logic [31:0] PFX_PRINT  = "M23 ";
   localparam logic [31:0] PFX_ESTOP  = "M112";
   localparam logic [31:0] PFX_REPORT = "M503";

   logic [7:0]    mem [LINE_LEN];
   logic [7:0]    rd_data_ff;
   logic          we;
   logic [LW-1:0] waddr;
   logic [7:0]    wdata;

   logic [1:0]    phase_ff, phase_in;
   logic [7:0]    esc_ff, esc_in;
   logic          discard_ff, discard_in;
   logic          comment_ff, comment_in;
   logic [LW-1:0] count_ff, count_in;
   logic          zero_seen_ff, zero_seen_in;
   logic [LW-1:0] zero_pos_ff, zero_pos_in;
   logic [7:0]    head_ff [5];
   logic [7:0]    head_in [5];

   logic          take;
   logic          fin;
   logic          comment_now;
   logic [7:0]    ch;
   logic [7:0]    hex;
   logic [LW-1:0] len;
   logic [31:0]   head_word;
   logic [7:0]    next_ch;
   logic          next_digit;
   logic          long_enough;

   function automatic logic [7:0] hex_val(input logic [7:0] c);
      logic letter;
      letter = (c inside {[CH_UP_A:CH_UP_Z]}) || (c inside {[CH_LO_A:CH_LO_Z]});
      return letter ? c - LETTER_OFS : c - CH_ZERO;
   endfunction

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

   always_comb begin
      phase_in     = phase_ff;
      esc_in       = esc_ff;
      discard_in   = discard_ff;
      comment_in   = comment_ff;
      count_in     = count_ff;
      zero_seen_in = zero_seen_ff;
      zero_pos_in  = zero_pos_ff;
      head_in      = head_ff;
      we           = 1'b0;
      waddr        = count_ff;
      wdata        = char_in;
      take         = 1'b0;
      fin          = 1'b0;
      comment_now  = comment_ff;
      ch           = char_in;
      hex          = hex_val(char_in);
      evt          = '0;

      if (start) begin
         if (eos) begin
            phase_in = PH_NONE;
            esc_in   = '0;
            if (!discard_ff) begin
               fin = 1'b1;
            end
            discard_in   = 1'b0;
            count_in     = '0;
            comment_in   = 1'b0;
            zero_seen_in = 1'b0;
         end else if (!discard_ff) begin
            if (phase_ff == PH_HIGH) begin
               esc_in   = {hex[3:0], 4'h0};
               phase_in = PH_LOW;
            end else if (phase_ff == PH_LOW) begin
               take     = 1'b1;
               ch       = esc_ff + hex;
               phase_in = PH_NONE;
               esc_in   = '0;
            end else if (web_on && char_in == CH_PERCENT) begin
               phase_in = PH_HIGH;
            end else begin
               take = 1'b1;
               ch   = (web_on && char_in == CH_PLUS) ? CH_SPACE : char_in;
            end
         end
      end

      if (take) begin
         if (ch == CH_NL) begin
            fin = 1'b1;
         end else begin
            comment_now = comment_ff | (ch == CH_SEMI);
            comment_in  = comment_now;
            if (count_ff >= LW'(LINE_LEN - 1)) begin
               if (ch != CH_SPACE && !comment_now) begin
                  evt.too_long = 1'b1;
                  discard_in   = 1'b1;
               end
            end else begin
               we       = 1'b1;
               wdata    = ch;
               count_in = count_ff + 1'b1;
               if (ch == 8'h00 && !zero_seen_ff) begin
                  zero_seen_in = 1'b1;
                  zero_pos_in  = count_ff;
               end
               if (count_ff < LW'(5)) begin
                  head_in[count_ff[2:0]] = ch;
               end
            end
         end
      end

      if (fin) begin
         we           = 1'b1;
         waddr        = count_ff;
         wdata        = 8'h00;
         count_in     = '0;
         comment_in   = 1'b0;
         zero_seen_in = 1'b0;
      end

      len         = zero_seen_ff ? zero_pos_ff : count_ff;
      head_word   = {head_ff[0], head_ff[1], head_ff[2], head_ff[3]};
      next_ch     = (len > LW'(4)) ? head_ff[4] : 8'h00;
      next_digit  = next_ch inside {[CH_ZERO:CH_NINE]};
      long_enough = len >= LW'(4);

      evt.finish = fin;
      evt.act    = ACT_QUEUE;
      if (long_enough) begin
         if (head_word == PFX_DELETE) begin
            evt.act = ACT_DELETE;
         end else if (head_word == PFX_PRINT) begin
            evt.act = ACT_PRINT;
         end else if (head_word == PFX_ESTOP && !next_digit) begin
            evt.act = ACT_ESTOP;
         end else if (head_word == PFX_REPORT && !next_digit) begin
            evt.act = ACT_REPORT;
         end
      end
   end

   assign len_out = len;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_NONE;
         esc_ff       <= '0;
         discard_ff   <= 1'b0;
         comment_ff   <= 1'b0;
         count_ff     <= '0;
         zero_seen_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         esc_ff       <= esc_in;
         discard_ff   <= discard_in;
         comment_ff   <= comment_in;
         count_ff     <= count_in;
         zero_seen_ff <= zero_seen_in;
      end
      zero_pos_ff <= zero_pos_in;
      head_ff     <= head_in;
   end

endmodule

`default_nettype wire

// ===== sv/clif_ring.sv =====
`default_nettype none

module clif_ring import clif_pkg::*; #(
   parameter int FIFO_DEPTH = 512
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire clif_ring_ctl_type             ctl,
   output      logic [7:0]                    rd_data,
   output      logic                          empty,
   output      logic [$clog2(FIFO_DEPTH)-1:0] free
);

   localparam int FW = $clog2(FIFO_DEPTH);

   logic [7:0]    mem [FIFO_DEPTH];
   logic [7:0]    rd_data_ff;
   logic [FW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FW:0]   span;
   logic [FW:0]   span_wrapped;

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[wr_ptr_ff] <= ctl.data;
      end
      rd_data_ff <= mem[rd_ptr_ff];
   end

   assign rd_data = rd_data_ff;
   assign empty   = rd_ptr_ff == wr_ptr_ff;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      if (ctl.pop) begin
         rd_ptr_in = (rd_ptr_ff == FW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (ctl.push) begin
         wr_ptr_in = (wr_ptr_ff == FW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      span = {1'b0, rd_ptr_ff} + (FW + 1)'(FIFO_DEPTH - 1) - {1'b0, wr_ptr_ff};
      span_wrapped = (span >= (FW + 1)'(FIFO_DEPTH)) ? span - (FW + 1)'(FIFO_DEPTH) : span;
      free = span_wrapped[FW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

endmodule

`default_nettype wire

// ===== verif/tb_command_line_intake_fifo.sv =====
`timescale 1ns / 1ps

module tb_command_line_intake_fifo;
   import clif_pkg::*;

   localparam int LINE_LEN     = 128;
   localparam int RING_DEPTH   = 512;
   localparam int DRAIN_CYCLES = 160;
   localparam int STALL_LIMIT  = 2000;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   typedef enum int {ESC_NONE, ESC_HIGH, ESC_LOW} esc_phase_type;

   typedef struct packed {
      logic        done;
      logic [15:0] count;
      logic [8:0]  space;
      logic [6:0]  len;
      logic [1:0]  err;
      logic [2:0]  act;
      logic        empty;
      logic [7:0]  data;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]   kind;
      logic [7:0]   ch;
      logic         eos;
      logic [6:0]   idx;
      logic         pick_idx;
      logic         has_fixed;
      rsp_item_type fixed;
   } req_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [8:0]  csr_wdata = '0;

   command_line_intake_fifo dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow copy of the intake state.
   logic [7:0]    line_mem [LINE_LEN];
   int            line_cnt;
   int            line_hi;
   bit            in_comment;
   bit            dropping;
   esc_phase_type esc_phase;
   logic [7:0]    esc_val;
   logic [7:0]    ring [RING_DEPTH];
   logic [8:0]    rd_ptr;
   logic [8:0]    wr_ptr;
   logic [15:0]   report_cnt;
   bit            web_on;
   logic [8:0]    space_max;
   logic [8:0]    space_min;
   rsp_item_type  pred;

   req_item_type  req_backlog [$];
   req_item_type  dir_rows [$];
   rsp_item_type  pending_rsp [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int side_pct = 0;
   int mismatch_count = 0;
   int total_items = 0;
   int settings_count = 0;
   int lines_closed = 0;
   int overflow_errs = 0;
   int full_errs = 0;
   int idle_cycles = 0;

   function automatic logic [8:0] ring_free();
      logic [8:0] f;
      f = rd_ptr - wr_ptr - 9'd1;
      return f;
   endfunction

   function automatic logic [8:0] reported_space();
      logic [8:0] f;
      f = ring_free();
      if (f > space_max) return space_max;
      if (f < space_min) return 9'd0;
      return f;
   endfunction

   function automatic logic [7:0] hex_val(logic [7:0] c);
      if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) return c - "A" + 8'd10;
      return c - "0";
   endfunction

   function automatic void close_line();
      int          len;
      logic [7:0]  nxt;
      logic [31:0] head;
      logic [2:0]  act;
      len = 0;
      while (len < line_cnt && line_mem[len] != 8'd0) len++;
      if (line_cnt < LINE_LEN) begin
         line_mem[line_cnt] = 8'd0;
         if (line_cnt > line_hi) line_hi = line_cnt;
      end
      nxt = (len > 4) ? line_mem[4] : 8'd0;
      head = {line_mem[0], line_mem[1], line_mem[2], line_mem[3]};
      act = ACT_QUEUE;
      if (len >= 4) begin
         if (head == "M30 ") act = ACT_DELETE;
         else if (head == "M23 ") act = ACT_PRINT;
         else if (head == "M112" && !(nxt >= "0" && nxt <= "9")) act = ACT_ESTOP;
         else if (head == "M503" && !(nxt >= "0" && nxt <= "9")) act = ACT_REPORT;
      end
      if (act == ACT_REPORT) report_cnt = report_cnt + 16'd1;
      if (act == ACT_QUEUE) begin
         if (len + 1 > int'(ring_free())) begin
            pred.err = ERR_NO_ROOM;
            full_errs++;
         end else begin
            for (int i = 0; i <= len; i++) begin
               ring[wr_ptr] = (i < len) ? line_mem[i] : 8'd0;
               wr_ptr = wr_ptr + 9'd1;
            end
         end
      end
      pred.done = 1'b1;
      pred.act = act;
      pred.len = 7'(len);
      line_cnt = 0;
      in_comment = 1'b0;
      lines_closed++;
   endfunction

   function automatic void take_char(logic [7:0] c);
      if (c == 8'h0A) begin
         close_line();
      end else begin
         if (c == ";") in_comment = 1'b1;
         if (line_cnt >= LINE_LEN - 1) begin
            if (c != " " && !in_comment) begin
               pred.err = ERR_TOO_LONG;
               dropping = 1'b1;
               overflow_errs++;
            end
         end else begin
            line_mem[line_cnt] = c;
            if (line_cnt > line_hi) line_hi = line_cnt;
            line_cnt++;
         end
      end
   endfunction

   function automatic void predict_intake(req_item_type it);
      logic [7:0] v;
      pred = '0;
      case (it.kind)
         KIND_TEXT: begin
            if (it.eos) begin
               esc_phase = ESC_NONE;
               esc_val = 8'd0;
               if (!dropping) close_line();
               dropping = 1'b0;
               line_cnt = 0;
               in_comment = 1'b0;
            end else if (!dropping) begin
               if (esc_phase == ESC_HIGH) begin
                  esc_val = hex_val(it.ch) << 4;
                  esc_phase = ESC_LOW;
               end else if (esc_phase == ESC_LOW) begin
                  v = esc_val + hex_val(it.ch);
                  esc_phase = ESC_NONE;
                  esc_val = 8'd0;
                  take_char(v);
               end else if (web_on && it.ch == "%") begin
                  esc_phase = ESC_HIGH;
               end else begin
                  take_char((web_on && it.ch == "+") ? 8'h20 : it.ch);
               end
            end
         end
         KIND_POP: begin
            if (rd_ptr == wr_ptr) begin
               pred.empty = 1'b1;
            end else begin
               pred.data = ring[rd_ptr];
               rd_ptr = rd_ptr + 9'd1;
            end
         end
         KIND_ARG: pred.data = line_mem[it.idx];
         default: ;
      endcase
      pred.space = reported_space();
      pred.count = report_cnt;
   endfunction

   function automatic void reset_shadow();
      line_cnt = 0;
      line_hi = -1;
      in_comment = 1'b0;
      dropping = 1'b0;
      esc_phase = ESC_NONE;
      esc_val = 8'd0;
      rd_ptr = 9'd0;
      wr_ptr = 9'd0;
      report_cnt = 16'd0;
      web_on = 1'b1;
      space_max = 9'd511;
      space_min = 9'd0;
   endfunction

   function automatic rsp_item_type quiet_rsp(logic empty, logic done, logic [2:0] act,
                                              logic [6:0] len, logic [15:0] count);
      rsp_item_type r;
      r = '0;
      r.empty = empty;
      r.done = done;
      r.act = act;
      r.len = len;
      r.space = 9'd511;
      r.count = count;
      return r;
   endfunction

   function automatic req_item_type row(logic [1:0] kind, logic [7:0] ch, logic eos,
                                        logic [6:0] idx);
      req_item_type it;
      it = '0;
      it.kind = kind;
      it.ch = ch;
      it.eos = eos;
      it.idx = idx;
      return it;
   endfunction

   function automatic req_item_type row_chk(logic [1:0] kind, logic [7:0] ch, logic eos,
                                            rsp_item_type want);
      req_item_type it;
      it = row(kind, ch, eos, 7'd0);
      it.has_fixed = 1'b1;
      it.fixed = want;
      return it;
   endfunction

   function automatic void push_item(logic [1:0] kind, logic [7:0] ch, logic eos, logic pick);
      req_item_type it;
      it = row(kind, ch, eos, 7'($urandom_range(127)));
      it.pick_idx = pick;
      req_backlog.push_back(it);
   endfunction

   function automatic void push_char(logic [7:0] ch);
      int r;
      push_item(KIND_TEXT, ch, 1'b0, 1'b0);
      if ($urandom_range(99) < side_pct) begin
         r = $urandom_range(9);
         if (r < 7) push_item(KIND_POP, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
         else if (r < 9) push_item(KIND_ARG, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
         else push_item(KIND_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
      end
   endfunction

   function automatic void push_eos();
      push_item(KIND_TEXT, 8'($urandom_range(255)), 1'b1, 1'b0);
   endfunction

   function automatic logic [7:0] hex_char();
      case ($urandom_range(7))
         0, 1, 2: return "0" + 8'($urandom_range(9));
         3, 4: return "A" + 8'($urandom_range(5));
         5: return "a" + 8'($urandom_range(5));
         6: return "A" + 8'($urandom_range(25));
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [7:0] body_char(bit allow_semi);
      int r;
      r = $urandom_range(99);
      if (r < 30) return "0" + 8'($urandom_range(9));
      if (r < 55) return "A" + 8'($urandom_range(25));
      if (r < 68) return " ";
      if (r < 76) return ".";
      if (r < 82) return "-";
      if (r < 88) return "a" + 8'($urandom_range(25));
      if (r < 95 || !allow_semi) return "+";
      return ";";
   endfunction

   function automatic void gen_line();
      int          sel;
      int          n;
      int          semi;
      logic [31:0] pfx;
      sel = $urandom_range(99);
      if (sel < 22) begin
         case ($urandom_range(3))
            0: pfx = "M30 ";
            1: pfx = "M23 ";
            2: pfx = "M112";
            default: pfx = "M503";
         endcase
         for (int i = 3; i >= 0; i--) push_char(pfx[8*i +: 8]);
         n = $urandom_range(5);
         for (int i = 0; i < n; i++) push_char(body_char(1'b1));
      end else if (sel < 28) begin
         n = $urandom_range(136, 118);
         semi = ($urandom_range(1) != 0) ? $urandom_range(126, 90) : -1;
         for (int i = 0; i < n; i++) begin
            if (i == semi) push_char(";");
            else if (i >= 127 && $urandom_range(1) != 0) push_char(" ");
            else push_char(body_char(1'b0));
         end
      end else if (sel < 36) begin
         n = $urandom_range(12, 1);
         for (int i = 0; i < n; i++) push_char(8'($urandom_range(255)));
      end else begin
         n = $urandom_range(20);
         for (int i = 0; i < n; i++) begin
            if (web_on && $urandom_range(99) < 8) begin
               push_char("%");
               push_char(hex_char());
               push_char(hex_char());
            end else begin
               push_char(body_char(1'b1));
            end
         end
      end
      sel = $urandom_range(99);
      if (sel < 70) begin
         push_eos();
      end else if (sel < 84) begin
         push_char(8'h0A);
      end else if (sel < 92 && web_on) begin
         push_char("%");
         push_char("0");
         push_char("A");
      end else begin
         if (web_on) begin
            push_char("%");
            if ($urandom_range(1) != 0) push_char(hex_char());
         end
         push_eos();
      end
   endfunction

   task automatic configure(input logic web, input logic [8:0] hi, input logic [8:0] lo);
      csr_we <= 1'b1;
      csr_index <= CSR_WEB_DECODE;
      csr_wdata <= {8'd0, web};
      @(posedge clock);
      csr_index <= CSR_SPACE_MAX;
      csr_wdata <= hi;
      @(posedge clock);
      csr_index <= CSR_SPACE_MIN;
      csr_wdata <= lo;
      @(posedge clock);
      csr_we <= 1'b0;
      web_on = web;
      space_max = hi;
      space_min = lo;
      settings_count++;
   endtask

   task automatic send_backlog();
      req_item_type cur;
      bit           busy;
      busy = 1'b0;
      while (req_backlog.size() != 0 || busy) begin
         @(posedge clock);
         if (busy && req_tready) begin
            predict_intake(cur);
            pending_rsp.push_back(cur.has_fixed ? cur.fixed : pred);
            total_items++;
            busy = 1'b0;
         end
         if (!busy) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cur = req_backlog.pop_front();
               if (cur.pick_idx) begin
                  if (line_hi < 0) cur.kind = KIND_POP;
                  else cur.idx = 7'($urandom_range(line_hi, 0));
               end
               req_tdata <= {1'b0, cur.idx, cur.ch};
               req_tlast <= cur.eos;
               req_tuser <= cur.kind;
               req_tvalid <= 1'b1;
               busy = 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   endtask

   task automatic drain();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tlast, rsp_tdata[45:0]};
         if (pending_rsp.size() == 0) begin
            $error("result item with nothing expected");
            mismatch_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (got.data !== want.data) begin
               $error("out_byte: expected %0d, got %0d", want.data, got.data);
               mismatch_count++;
            end
            if (got.empty !== want.empty) begin
               $error("fifo_was_empty: expected %0d, got %0d", want.empty, got.empty);
               mismatch_count++;
            end
            if (got.done !== want.done) begin
               $error("line_done: expected %0d, got %0d", want.done, got.done);
               mismatch_count++;
            end
            if (got.act !== want.act) begin
               $error("action: expected %0d, got %0d", want.act, got.act);
               mismatch_count++;
            end
            if (got.err !== want.err) begin
               $error("error_code: expected %0d, got %0d", want.err, got.err);
               mismatch_count++;
            end
            if (got.len !== want.len) begin
               $error("line_length: expected %0d, got %0d", want.len, got.len);
               mismatch_count++;
            end
            if (got.space !== want.space) begin
               $error("reported_space: expected %0d, got %0d", want.space, got.space);
               mismatch_count++;
            end
            if (got.count !== want.count) begin
               $error("report_count: expected %0d, got %0d", want.count, got.count);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $error("no item moved for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      reset_shadow();
      configure(1'b1, 9'd511, 9'd0);
      send_idle_pct = 20;
      recv_idle_pct = 83;

      dir_rows = '{
         row_chk(KIND_POP, 8'h00, 1'b0, quiet_rsp(1'b1, 1'b0, ACT_QUEUE, 7'd0, 16'd0)),
         row_chk(KIND_UNUSED, 8'hFF, 1'b1, quiet_rsp(1'b0, 1'b0, ACT_QUEUE, 7'd0, 16'd0)),
         row(KIND_TEXT, "M", 1'b0, 7'd0),
         row(KIND_TEXT, "5", 1'b0, 7'd0),
         row(KIND_TEXT, "0", 1'b0, 7'd0),
         row(KIND_TEXT, "3", 1'b0, 7'd0),
         row_chk(KIND_TEXT, 8'h00, 1'b1, quiet_rsp(1'b0, 1'b1, ACT_REPORT, 7'd4, 16'd1)),
         row(KIND_TEXT, "M", 1'b0, 7'd0),
         row(KIND_TEXT, "1", 1'b0, 7'd0),
         row(KIND_TEXT, "1", 1'b0, 7'd0),
         row(KIND_TEXT, "2", 1'b0, 7'd0),
         row_chk(KIND_TEXT, 8'h0A, 1'b0, quiet_rsp(1'b0, 1'b1, ACT_ESTOP, 7'd4, 16'd1)),
         row(KIND_TEXT, 8'hFF, 1'b0, 7'd0),
         row(KIND_TEXT, "+", 1'b0, 7'd0),
         row(KIND_TEXT, "%", 1'b0, 7'd0),
         row(KIND_TEXT, "4", 1'b0, 7'd0),
         row(KIND_TEXT, "a", 1'b0, 7'd0),
         row(KIND_TEXT, "%", 1'b0, 7'd0),
         row(KIND_TEXT, "0", 1'b0, 7'd0),
         row(KIND_TEXT, "0", 1'b0, 7'd0),
         row(KIND_TEXT, 8'h00, 1'b1, 7'd127),
         row(KIND_ARG, 8'h00, 1'b0, 7'd1),
         row(KIND_TEXT, "%", 1'b0, 7'd0),
         row(KIND_TEXT, "0", 1'b0, 7'd0),
         row(KIND_TEXT, "A", 1'b0, 7'd0),
         row(KIND_TEXT, "%", 1'b0, 7'd0),
         row(KIND_TEXT, 8'h00, 1'b1, 7'd0)
      };
      foreach (dir_rows[i]) req_backlog.push_back(dir_rows[i]);
      send_backlog();
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: configure(1'b1, 9'd511, 9'd0);
            1: configure(1'b0, 9'd100, 9'd20);
            2: configure(1'b1, 9'd0, 9'd0);
            3: configure(1'b1, 9'd511, 9'd511);
            4: configure(1'b0, 9'($urandom_range(511)), 9'($urandom_range(511)));
            default: configure(1'b1, 9'd511, 9'd0);
         endcase
         case (ph)
            0: side_pct = 3;
            1: side_pct = 3;
            2: side_pct = 35;
            3: side_pct = 10;
            4: side_pct = 2;
            default: side_pct = 45;
         endcase
         send_idle_pct = (ph < 2) ? 20 : (ph < 4) ? 83 : 0;
         recv_idle_pct = (ph < 2) ? 83 : (ph < 4) ? 20 : 0;
         while (req_backlog.size() < 275) gen_line();
         send_backlog();
         drain();
      end

      $display("Ran %0d items through %0d register settings and three idling patterns.",
               total_items, settings_count);
      $display("%0d lines finished, %0d overlong, %0d refused for lack of FIFO room.",
               lines_closed, overflow_errs, full_errs);
      if (mismatch_count == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

endmodule
